[hw/rtl/s64dec_pkg.sv]
package s64dec_pkg;

  // Field and storage widths.
  localparam int unsigned MAG_W  = 64;
  localparam int unsigned NDIG   = 19;
  localparam int unsigned BCD_W  = 4 * NDIG;
  localparam int unsigned ITER_W = 6;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned BUF_W  = 7;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [3:0]        CH_DIGIT_HI = 4'h3;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  // Register map and reset value.
  localparam logic            REG_BUFFER_SIZE = 1'b0;
  localparam logic [BUF_W-1:0] BUF_RESET      = 7'd64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic size;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_last;
  } sts_t;

endpackage

[hw/rtl/s64dec_dp.sv]
module s64dec_dp (
  input  logic                            clk,
  input  s64dec_pkg::cmd_t                cmd,
  output s64dec_pkg::sts_t                sts,
  input  logic [s64dec_pkg::MAG_W-1:0]    value,
  input  logic [s64dec_pkg::BUF_W-1:0]    buffer_size,
  output logic [s64dec_pkg::CHAR_W-1:0]   char_code,
  output logic                            last_char,
  output logic [s64dec_pkg::LEN_W-1:0]    total_length,
  output logic                            too_long
);

  logic [s64dec_pkg::MAG_W-1:0]  mag_r;
  logic [s64dec_pkg::BCD_W-1:0]  bcd_r;
  logic                          neg_r;
  logic [s64dec_pkg::LEN_W-1:0]  len_r;
  logic                          too_r;
  logic [s64dec_pkg::LEN_W-1:0]  pos_r;
  logic [s64dec_pkg::CHAR_W-1:0] char_r;
  logic                          last_r;
  logic [s64dec_pkg::LEN_W-1:0]  olen_r;
  logic                          otoo_r;

  logic [s64dec_pkg::BCD_W-1:0]  bcd_adj;
  logic [s64dec_pkg::LEN_W-1:0]  top_dig;
  logic [s64dec_pkg::LEN_W-1:0]  ndig;
  logic [s64dec_pkg::LEN_W-1:0]  textlen;
  logic [s64dec_pkg::LEN_W-1:0]  didx;
  logic [3:0]                    digit;
  logic                          is_minus;
  logic                          cur_last;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < s64dec_pkg::NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Position of the highest nonzero digit; zero still has one digit.
  always_comb begin
    top_dig = '0;
    for (int i = 0; i < s64dec_pkg::NDIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        top_dig = s64dec_pkg::LEN_W'(i + 1);
      end
    end
    ndig    = (top_dig == '0) ? s64dec_pkg::LEN_W'(1) : top_dig;
    textlen = ndig + {{(s64dec_pkg::LEN_W-1){1'b0}}, neg_r};
  end

  // Character at the current text position.
  always_comb begin
    is_minus = neg_r && (pos_r == '0);
    didx     = len_r - s64dec_pkg::LEN_W'(1) - pos_r;
    digit    = bcd_r[{didx, 2'b00} +: 4];
    cur_last = too_r || (pos_r == (len_r - s64dec_pkg::LEN_W'(1)));
  end

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= value[s64dec_pkg::MAG_W-1];
      mag_r <= value[s64dec_pkg::MAG_W-1] ? (~value + s64dec_pkg::MAG_W'(1)) : value;
      bcd_r <= '0;
    end else if (cmd.shift) begin
      bcd_r <= {bcd_adj[s64dec_pkg::BCD_W-2:0], mag_r[s64dec_pkg::MAG_W-1]};
      mag_r <= {mag_r[s64dec_pkg::MAG_W-2:0], 1'b0};
    end
    if (cmd.size) begin
      len_r <= textlen;
      too_r <= ({{(s64dec_pkg::BUF_W-s64dec_pkg::LEN_W){1'b0}}, textlen} >= buffer_size);
      pos_r <= '0;
    end else if (cmd.emit) begin
      pos_r <= pos_r + s64dec_pkg::LEN_W'(1);
    end
  end

  // Output register, loaded with one beat at a time.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (too_r) begin
        char_r <= s64dec_pkg::CH_NONE;
        olen_r <= '0;
      end else begin
        char_r <= is_minus ? s64dec_pkg::CH_MINUS : {s64dec_pkg::CH_DIGIT_HI, digit};
        olen_r <= len_r;
      end
      last_r <= cur_last;
      otoo_r <= too_r;
    end
  end

  assign sts.cur_last = cur_last;
  assign char_code    = char_r;
  assign last_char    = last_r;
  assign total_length = olen_r;
  assign too_long     = otoo_r;

endmodule

[hw/rtl/s64dec_ctrl.sv]
module s64dec_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  s64dec_pkg::sts_t sts,
  output s64dec_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic [s64dec_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  // The output register can take a beat when empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        cnt_nxt   = cnt_r + s64dec_pkg::ITER_W'(1);
        if (cnt_r == '1) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.cur_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted beat starts the conversion.
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CONV) && (cnt_r == '0))
    else $error("accepted beat did not start conversion");

  // The shift counter steps by one through the conversion.
  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) && (cnt_r != '1) |=>
      (state_r == ST_CONV) && (cnt_r == $past(cnt_r) + s64dec_pkg::ITER_W'(1)))
    else $error("conversion counter skipped");

  // A new beat never overwrites one that is stalled at the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("output register overwritten while stalled");

  // Sizing always leads straight to emission.
  a_size_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIZE) |=> (state_r == ST_EMIT))
    else $error("sizing not followed by emission");

endmodule

[hw/rtl/signed_int64_to_decimal_ascii.sv]
// Channel | Direction | Payload                                          | Handshake
// in      | input     | in_value[63:0] signed                            | in_valid/in_ready
// out     | output    | out_char_code, out_last_char, out_total_length,  | out_valid/out_ready
//         |           | out_too_long                                     |
// cfg     | input     | buffer_size at byte address 0, 7 bits            | APB, cfg_pready = 1
//
// One item is accepted, converted by a 64-step double-dabble shift of the BCD
// register, sized, and then sent as one result beat at a time, 1 to 20 beats
// per item, each beat held until the output register can take it.
// Reset is synchronous and active low; it clears the controller and sets
// buffer_size to 64. A stalled result holds in the output register; the next
// item is accepted as soon as the last beat of the current one is loaded.
module signed_int64_to_decimal_ascii (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [s64dec_pkg::MAG_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [s64dec_pkg::CHAR_W-1:0]    out_char_code,
  output logic                             out_last_char,
  output logic [s64dec_pkg::LEN_W-1:0]     out_total_length,
  output logic                             out_too_long,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [s64dec_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [s64dec_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [s64dec_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                             cfg_pready
);

  logic [s64dec_pkg::BUF_W-1:0] buffer_size_r;
  s64dec_pkg::cmd_t             cmd;
  s64dec_pkg::sts_t             sts;

  // Configuration register; writes to other addresses are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= s64dec_pkg::BUF_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == s64dec_pkg::REG_BUFFER_SIZE)) begin
      buffer_size_r <= cfg_pwdata[s64dec_pkg::BUF_W-1:0];
    end
  end

  // Read back.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == s64dec_pkg::REG_BUFFER_SIZE) ?
      {{(s64dec_pkg::DATA_W-s64dec_pkg::BUF_W){1'b0}}, buffer_size_r} : '0;

  s64dec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  s64dec_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .sts          (sts),
    .value        (in_value),
    .buffer_size  (buffer_size_r),
    .char_code    (out_char_code),
    .last_char    (out_last_char),
    .total_length (out_total_length),
    .too_long     (out_too_long)
  );

endmodule

[tb/sv/signed_int64_to_decimal_ascii_tb.sv]
// One character beat of decimal text as the result channel carries it.
typedef struct packed {
  logic [s64dec_pkg::CHAR_W-1:0] char_code;
  logic                          last_char;
  logic [s64dec_pkg::LEN_W-1:0]  total_length;
  logic                          too_long;
} text_beat_t;

// Predicts the character beats of each accepted value and checks them in order.
class decimal_text_scoreboard;
  text_beat_t                     pending_chars[$];
  logic [s64dec_pkg::BUF_W-1:0]   buffer_size;
  int unsigned                    mismatches;
  int unsigned                    beats_seen;

  function new();
    buffer_size = s64dec_pkg::BUF_RESET;
    mismatches  = 0;
    beats_seen  = 0;
  endfunction

  // Print one line per mismatch and count every one.
  task report(string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  function void write_reg(int unsigned index, logic [31:0] data);
    // Writes to an index past the register map are dropped.
    if (index == s64dec_pkg::REG_BUFFER_SIZE) begin
      buffer_size = data[s64dec_pkg::BUF_W-1:0];
    end
  endfunction

  function int unsigned pending();
    return pending_chars.size();
  endfunction

  // Convert one value to its expected beats.
  function void note_input(logic [63:0] value);
    logic        negative;
    logic [63:0] magnitude;
    logic [3:0]  digits [20];
    int          ndigits;
    int          text_len;
    text_beat_t  beat;

    negative  = value[63];
    magnitude = negative ? (~value + 64'd1) : value;

    // Digits come out least significant first.
    ndigits = 0;
    do begin
      digits[ndigits] = 4'(magnitude % 64'd10);
      magnitude       = magnitude / 64'd10;
      ndigits++;
    end while (magnitude != 64'd0 && ndigits < 19);
    text_len = ndigits + int'(negative);

    // Text that leaves no room for a terminator becomes a single flag beat.
    if (text_len >= buffer_size) begin
      beat = '{char_code: s64dec_pkg::CH_NONE, last_char: 1'b1,
               total_length: '0, too_long: 1'b1};
      pending_chars.push_back(beat);
      return;
    end

    if (negative) begin
      beat = '{char_code: s64dec_pkg::CH_MINUS, last_char: 1'b0,
               total_length: s64dec_pkg::LEN_W'(text_len), too_long: 1'b0};
      pending_chars.push_back(beat);
    end
    for (int i = ndigits - 1; i >= 0; i--) begin
      beat = '{char_code: {s64dec_pkg::CH_DIGIT_HI, digits[i]}, last_char: (i == 0),
               total_length: s64dec_pkg::LEN_W'(text_len), too_long: 1'b0};
      pending_chars.push_back(beat);
    end
  endfunction

  // Compare an accepted beat with the oldest expected one.
  task check_result(logic [s64dec_pkg::CHAR_W-1:0] char_code, logic last_char,
                    logic [s64dec_pkg::LEN_W-1:0] total_length, logic too_long);
    text_beat_t want;

    beats_seen++;
    if (pending_chars.size() == 0) begin
      report($sformatf("beat %0d arrived with nothing expected: char %h last %b len %0d long %b",
                       beats_seen, char_code, last_char, total_length, too_long));
      return;
    end
    want = pending_chars.pop_front();
    if (char_code !== want.char_code || last_char !== want.last_char ||
        total_length !== want.total_length || too_long !== want.too_long) begin
      report($sformatf("beat %0d: got char %h last %b len %0d long %b, want %h %b %0d %b",
                       beats_seen, char_code, last_char, total_length, too_long,
                       want.char_code, want.last_char, want.total_length, want.too_long));
    end
  endtask
endclass

module signed_int64_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import s64dec_pkg::*;

  typedef logic [ADDR_W-1:0] apb_addr_t;

  localparam int unsigned REG_UNUSED      = 1;
  localparam int unsigned NUM_PHASES      = 12;
  localparam int unsigned ITEMS_PER_PHASE = 28;
  localparam int unsigned MAX_IDLE        = 17;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MAG_W-1:0]  in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char_code;
  logic              out_last_char;
  logic [LEN_W-1:0]  out_total_length;
  logic              out_too_long;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  apb_addr_t         cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int unsigned cycle_count = 0;

  decimal_text_scoreboard scoreboard = new();

  // Boundary values: zero, signs, digit-count edges and both int64 extremes.
  logic [63:0] directed_values [23] = '{
    64'd0, 64'd1, -64'd1, 64'd9, 64'd10, -64'd10, 64'd99, 64'd100, -64'd99, -64'd100,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
    -64'd9, 64'd12345, -64'd1000000000000, 64'd1000000000000000000,
    64'd999999999999999999, -64'd1000000000000000000,
    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd4294967296,
    -64'd999999999999999999
  };

  signed_int64_to_decimal_ascii i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_char_code    (out_char_code),
    .out_last_char    (out_last_char),
    .out_total_length (out_total_length),
    .out_too_long     (out_too_long),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_cycles(bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Mostly random magnitudes of random length, some near powers of ten,
  // some at the int64 extremes; sign chosen at random.
  function automatic logic [63:0] random_value();
    logic [63:0]  magnitude;
    logic [63:0]  ten_pow;
    int unsigned  exponent;

    ten_pow = 64'd1;
    case ($urandom_range(0, 9))
      0, 1: begin
        exponent = $urandom_range(0, 18);
        for (int i = 0; i < exponent; i++) ten_pow = ten_pow * 64'd10;
        magnitude = ten_pow + 64'($urandom_range(0, 2)) - 64'd1;
      end
      2: begin
        magnitude = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      default: begin
        magnitude = {$urandom, $urandom} >> $urandom_range(0, 63);
      end
    endcase
    return $urandom_range(0, 1) ? (~magnitude + 64'd1) : magnitude;
  endfunction

  // Offer one value, hold it until accepted, then idle for a drawn gap.
  task automatic send_value(logic [63:0] value);
    int unsigned gap;

    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    scoreboard.note_input(value);
    gap = idle_cycles(in_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Register write: a setup phase, then an access phase held until pready.
  task automatic write_cfg(int unsigned index, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= apb_addr_t'(4 * index);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    scoreboard.write_reg(index, data);
  endtask

  // Every value yields at least one beat, so an empty queue means idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (scoreboard.pending() != 0);
  endtask

  // Result side: stall for a drawn number of cycles before each beat.
  initial begin
    int unsigned stall;

    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = idle_cycles(out_quiet);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      scoreboard.check_result(out_char_code, out_last_char, out_total_length, out_too_long);
    end
  end

  // Main sequence: boundary values at the reset size, then random phases.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_values[i]) send_value(directed_values[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        0:       write_cfg(REG_BUFFER_SIZE, 32'd0);
        1:       write_cfg(REG_BUFFER_SIZE, 32'd1);
        2:       write_cfg(REG_BUFFER_SIZE, 32'd2);
        3:       write_cfg(REG_BUFFER_SIZE, 32'd20);
        4:       write_cfg(REG_BUFFER_SIZE, 32'd21);
        5:       write_cfg(REG_BUFFER_SIZE, 32'd127);
        // Upper data bits set; only the low seven bits land.
        6:       write_cfg(REG_BUFFER_SIZE, 32'hFFFF_FF8A);
        // A write past the register map must leave the size alone.
        7:       write_cfg(REG_UNUSED, 32'd3);
        11:      write_cfg(REG_BUFFER_SIZE, 32'd64);
        default: write_cfg(REG_BUFFER_SIZE, $urandom_range(3, 22));
      endcase
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) send_value(random_value());
    end

    // Let any stray beat show up before judging.
    wait_drained();
    repeat (40) @(posedge clk);
    if (scoreboard.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[signed_int64_to_decimal_ascii.f]
hw/rtl/s64dec_pkg.sv
hw/rtl/s64dec_dp.sv
hw/rtl/s64dec_ctrl.sv
hw/rtl/signed_int64_to_decimal_ascii.sv
tb/sv/signed_int64_to_decimal_ascii_tb.sv
